// ----- hw/rtl/dqmb_pkg.sv -----
package dqmb_pkg;

    localparam int MAX_LABEL_CHARS = 63;
    localparam int LEN_W = 6;
    localparam int SEQ_W = 4;

    localparam logic [7:0]  DOT_CHAR   = 8'd46;
    localparam logic [15:0] FLAGS_WORD = 16'h0100;
    localparam logic [15:0] QCLASS_IN  = 16'd1;
    localparam logic [15:0] QD_COUNT   = 16'd1;
    localparam logic [15:0] OPT_TYPE   = 16'd41;
    localparam logic [15:0] OPT_SIZE   = 16'd4096;

    localparam logic [LEN_W-1:0] HDR_BYTES      = 6'd12;
    localparam logic [LEN_W-1:0] TRL_BYTES_BASE = 6'd5;
    localparam logic [LEN_W-1:0] TRL_BYTES_OPT  = 6'd16;

    localparam logic [1:0] ONE_BYTE  = 2'd1;
    localparam logic [1:0] TWO_BYTES = 2'd2;

    typedef enum logic [0:0] {
        REG_RECORD_TYPE = 1'b0,
        REG_EDNS_ENABLE = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_HDR,
        PH_LEN,
        PH_CHR,
        PH_TRL,
        PH_FLUSH
    } phase_t;

    typedef struct packed {
        logic [15:0] query_id;
        logic [7:0]  name_byte;
        logic        byte_valid;
        logic        end_of_name;
    } item_t;

    typedef struct packed {
        logic [15:0] message_word;
        logic [1:0]  bytes_in_word;
        logic        last_word;
    } word_t;

    typedef struct packed {
        logic             in_ready;
        phase_t           phase;
        logic [LEN_W-1:0] cnt;
        logic [LEN_W-1:0] rd_addr;
        logic             emit;
        logic             final_byte;
        logic             flush;
        logic             clear_label;
        logic             clear_header;
    } cmd_t;

    typedef struct packed {
        logic             accept;
        logic             header_sent;
        logic             item_dot;
        logic             item_last;
        logic [LEN_W-1:0] label_len;
        logic             edns;
        logic             carry_present;
        logic             byte_ok;
    } status_t;

    function automatic logic [7:0] hdr_byte(input logic [SEQ_W-1:0] idx,
                                            input logic [15:0] qid,
                                            input logic edns);
        logic [7:0] b;
        case (idx)
            4'd0:    b = qid[15:8];
            4'd1:    b = qid[7:0];
            4'd2:    b = FLAGS_WORD[15:8];
            4'd3:    b = FLAGS_WORD[7:0];
            4'd4:    b = QD_COUNT[15:8];
            4'd5:    b = QD_COUNT[7:0];
            4'd11:   b = {7'd0, edns};
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] trl_byte(input logic [SEQ_W-1:0] idx,
                                            input logic [15:0] rtype);
        logic [7:0] b;
        case (idx)
            4'd1:    b = rtype[15:8];
            4'd2:    b = rtype[7:0];
            4'd3:    b = QCLASS_IN[15:8];
            4'd4:    b = QCLASS_IN[7:0];
            4'd6:    b = OPT_TYPE[15:8];
            4'd7:    b = OPT_TYPE[7:0];
            4'd8:    b = OPT_SIZE[15:8];
            4'd9:    b = OPT_SIZE[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/dqmb_stream_if.sv -----
interface dqmb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dqmb_ctrl.sv -----
module dqmb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  dqmb_pkg::status_t  status,
    output dqmb_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_ROUTE,
        S_LEN,
        S_CHR,
        S_TRL,
        S_FLUSH
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [dqmb_pkg::LEN_W-1:0] cnt_reg;
    logic [dqmb_pkg::LEN_W-1:0] cnt_next;
    logic [dqmb_pkg::LEN_W-1:0] trl_end;
    state_t                     after_label;

    assign trl_end = (status.edns ? dqmb_pkg::TRL_BYTES_OPT : dqmb_pkg::TRL_BYTES_BASE)
                     - dqmb_pkg::LEN_W'(1);
    assign after_label = status.item_last ? S_TRL : S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.phase  = dqmb_pkg::PH_NONE;
        cmd.in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (status.accept)
                begin
                    cnt_next   = '0;
                    state_next = status.header_sent ? S_ROUTE : S_HDR;
                end
            end
            S_HDR:
            begin
                cmd.phase = dqmb_pkg::PH_HDR;
                cmd.emit  = status.byte_ok;
                if (status.byte_ok)
                begin
                    if (cnt_reg == dqmb_pkg::HDR_BYTES - dqmb_pkg::LEN_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = S_ROUTE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + dqmb_pkg::LEN_W'(1);
                    end
                end
            end
            S_ROUTE:
            begin
                cnt_next = '0;
                if (status.item_dot || (status.item_last && status.label_len != '0))
                begin
                    state_next = S_LEN;
                end
                else if (status.item_last)
                begin
                    state_next = S_TRL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LEN:
            begin
                cmd.phase = dqmb_pkg::PH_LEN;
                cmd.emit  = status.byte_ok;
                cnt_next  = '0;
                if (status.byte_ok)
                begin
                    if (status.label_len == '0)
                    begin
                        cmd.clear_label = 1'b1;
                        state_next      = after_label;
                    end
                    else
                    begin
                        state_next = S_CHR;
                    end
                end
            end
            S_CHR:
            begin
                cmd.phase = dqmb_pkg::PH_CHR;
                cmd.emit  = status.byte_ok;
                if (status.byte_ok)
                begin
                    if (cnt_reg == status.label_len - dqmb_pkg::LEN_W'(1))
                    begin
                        cmd.clear_label = 1'b1;
                        cnt_next        = '0;
                        state_next      = after_label;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + dqmb_pkg::LEN_W'(1);
                    end
                end
            end
            S_TRL:
            begin
                cmd.phase      = dqmb_pkg::PH_TRL;
                cmd.emit       = status.byte_ok;
                cmd.final_byte = (cnt_reg == trl_end);
                if (status.byte_ok)
                begin
                    if (cnt_reg == trl_end)
                    begin
                        cmd.clear_header = 1'b1;
                        cnt_next         = '0;
                        state_next       = status.carry_present ? S_IDLE : S_FLUSH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + dqmb_pkg::LEN_W'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                cmd.phase = dqmb_pkg::PH_FLUSH;
                if (status.byte_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.cnt     = cnt_reg;
        cmd.rd_addr = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/dqmb_datapath.sv -----
module dqmb_datapath #(
    parameter int MAX_LABEL_CHARS = dqmb_pkg::MAX_LABEL_CHARS
) (
    input  logic               clk,
    input  logic               rst_n,
    dqmb_stream_if.sink        chars,
    dqmb_stream_if.source      words,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  dqmb_pkg::cmd_t     cmd,
    output dqmb_pkg::status_t  status
);

    localparam int IDX_W = (MAX_LABEL_CHARS > 1) ? $clog2(MAX_LABEL_CHARS) : 1;
    localparam logic [dqmb_pkg::LEN_W-1:0] LEN_LIMIT = dqmb_pkg::LEN_W'(MAX_LABEL_CHARS);

    logic [7:0]                 label_mem [MAX_LABEL_CHARS];
    logic [7:0]                 rd_data_reg;

    logic [15:0]                record_type_reg;
    logic                       edns_reg;
    logic                       header_sent_reg;
    logic [dqmb_pkg::LEN_W-1:0] label_len_reg;
    logic [7:0]                 carry_reg;
    logic                       carry_present_reg;
    logic [15:0]                qid_reg;
    logic                       item_dot_reg;
    logic                       item_last_reg;
    logic [15:0]                out_word_reg;
    logic [1:0]                 out_bytes_reg;
    logic                       out_last_reg;
    logic                       out_valid_reg;

    logic                       accept;
    logic                       store_char;
    logic                       byte_ok;
    logic                       load_word;
    logic [7:0]                 byte_value;

    assign accept     = chars.valid && cmd.in_ready;
    assign store_char = accept && chars.data.byte_valid
                        && (chars.data.name_byte != dqmb_pkg::DOT_CHAR)
                        && (label_len_reg < LEN_LIMIT);
    assign byte_ok    = !out_valid_reg || words.ready;
    assign load_word  = (cmd.emit && carry_present_reg) || cmd.flush;

    assign chars.ready = cmd.in_ready;
    assign words.valid = out_valid_reg;
    assign words.data.message_word  = out_word_reg;
    assign words.data.bytes_in_word = out_bytes_reg;
    assign words.data.last_word     = out_last_reg;

    assign status.accept        = accept;
    assign status.header_sent   = header_sent_reg;
    assign status.item_dot      = item_dot_reg;
    assign status.item_last     = item_last_reg;
    assign status.label_len     = label_len_reg;
    assign status.edns          = edns_reg;
    assign status.carry_present = carry_present_reg;
    assign status.byte_ok       = byte_ok;

    always_comb
    begin
        case (cmd.phase)
            dqmb_pkg::PH_HDR:
                byte_value = dqmb_pkg::hdr_byte(cmd.cnt[dqmb_pkg::SEQ_W-1:0], qid_reg, edns_reg);
            dqmb_pkg::PH_LEN:
                byte_value = {2'b00, label_len_reg};
            dqmb_pkg::PH_CHR:
                byte_value = rd_data_reg;
            dqmb_pkg::PH_TRL:
                byte_value = dqmb_pkg::trl_byte(cmd.cnt[dqmb_pkg::SEQ_W-1:0], record_type_reg);
            default:
                byte_value = 8'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (store_char)
        begin
            label_mem[label_len_reg[IDX_W-1:0]] <= chars.data.name_byte;
        end
        rd_data_reg <= label_mem[cmd.rd_addr[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qid_reg <= chars.data.query_id;
        end
        if (load_word)
        begin
            if (cmd.flush)
            begin
                out_word_reg  <= {carry_reg, 8'd0};
                out_bytes_reg <= dqmb_pkg::ONE_BYTE;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_word_reg  <= {carry_reg, byte_value};
                out_bytes_reg <= dqmb_pkg::TWO_BYTES;
                out_last_reg  <= cmd.final_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_type_reg   <= 16'd1;
            edns_reg          <= 1'b1;
            header_sent_reg   <= 1'b0;
            label_len_reg     <= '0;
            carry_reg         <= 8'd0;
            carry_present_reg <= 1'b0;
            item_dot_reg      <= 1'b0;
            item_last_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dqmb_pkg::REG_RECORD_TYPE: record_type_reg <= cfg_data;
                    dqmb_pkg::REG_EDNS_ENABLE: edns_reg        <= cfg_data[0];
                    default:                   edns_reg        <= edns_reg;
                endcase
            end

            if (accept)
            begin
                header_sent_reg <= 1'b1;
                item_dot_reg    <= chars.data.byte_valid
                                   && (chars.data.name_byte == dqmb_pkg::DOT_CHAR);
                item_last_reg   <= chars.data.end_of_name;
            end
            else if (cmd.clear_header)
            begin
                header_sent_reg <= 1'b0;
            end

            if (store_char)
            begin
                label_len_reg <= label_len_reg + dqmb_pkg::LEN_W'(1);
            end
            else if (cmd.clear_label)
            begin
                label_len_reg <= '0;
            end

            if (load_word)
            begin
                carry_present_reg <= 1'b0;
            end
            else if (cmd.emit)
            begin
                carry_reg         <= byte_value;
                carry_present_reg <= 1'b1;
            end

            if (load_word)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (words.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/dns_query_message_builder.sv -----
// Channel   Dir   Word payload
// chars     in    query_id[15:0], name_byte[7:0], byte_valid, end_of_name
// words     out   message_word[15:0], bytes_in_word[1:0], last_word
// cfg       in    cfg_we, cfg_index (0 record_type, 1 edns_enable), cfg_data[15:0]
//
// One message byte is produced per cycle into a 16-bit word packer while the output
// register is not stalled. An item causes 12 bytes for the header on the first item
// of a name, 1 + n for a label of n characters and 5 or 16 for the trailer, and an
// odd final byte is flushed on its own. A new item is taken only once the previous one
// is finished. The output register stalls byte generation while it holds an
// untaken word. Reset clears all control state and sets both registers to 1.
module dns_query_message_builder #(
    parameter int MAX_LABEL_CHARS = dqmb_pkg::MAX_LABEL_CHARS
) (
    input  logic           clk,
    input  logic           rst_n,
    dqmb_stream_if.sink    chars,
    dqmb_stream_if.source  words,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data
);

    dqmb_pkg::cmd_t    cmd;
    dqmb_pkg::status_t status;

    dqmb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    dqmb_datapath #(
        .MAX_LABEL_CHARS (MAX_LABEL_CHARS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .words     (words),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        words.valid && words.data.bytes_in_word == dqmb_pkg::ONE_BYTE
        |-> words.data.last_word)
        else $error("Odd word is not the last word of the message.");

    assert property (@(posedge clk) disable iff (!rst_n)
        words.valid |-> (words.data.bytes_in_word == dqmb_pkg::ONE_BYTE
                         || words.data.bytes_in_word == dqmb_pkg::TWO_BYTES))
        else $error("Word carries an invalid byte count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        words.valid && words.data.bytes_in_word == dqmb_pkg::ONE_BYTE
        |-> words.data.message_word[7:0] == 8'd0)
        else $error("Odd word has a nonzero lower byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.ready |=> !chars.ready)
        else $error("New word accepted before the previous one was processed.");
`endif

endmodule

// ----- verif/query_word_checker.sv -----
`timescale 1ns / 1ps

module query_word_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  dqmb_pkg::item_t   in_item,
    input  logic              out_valid,
    input  logic              out_ready,
    input  dqmb_pkg::word_t   out_word,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    output int                mismatches,
    output int                words_pending
);

    logic [15:0]     rec_type;
    logic            edns_on;
    logic [7:0]      label_buf [0:dqmb_pkg::MAX_LABEL_CHARS-1];
    int              label_len;
    logic            in_name;
    logic [7:0]      carry_byte;
    logic            carry_valid;
    logic [7:0]      msg_bytes [0:127];
    int              msg_len;
    dqmb_pkg::word_t expected_words [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: word mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        msg_bytes[msg_len] = b;
        msg_len++;
    endtask

    task automatic add_word(input logic [15:0] w);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endtask

    task automatic add_label();
        add_byte(8'(label_len));
        for (int i = 0; i < label_len; i++)
        begin
            add_byte(label_buf[i]);
        end
        label_len = 0;
    endtask

    task automatic predict_words(input dqmb_pkg::item_t it);
        dqmb_pkg::word_t w;
        msg_len = 0;
        if (!in_name)
        begin
            add_word(it.query_id);
            add_word(dqmb_pkg::FLAGS_WORD);
            add_word(dqmb_pkg::QD_COUNT);
            add_word(16'd0);
            add_word(16'd0);
            add_word(edns_on ? 16'd1 : 16'd0);
            in_name = 1'b1;
        end
        if (it.byte_valid)
        begin
            if (it.name_byte == dqmb_pkg::DOT_CHAR)
            begin
                add_label();
            end
            else if (label_len < dqmb_pkg::MAX_LABEL_CHARS)
            begin
                label_buf[label_len] = it.name_byte;
                label_len++;
            end
        end
        if (it.end_of_name)
        begin
            if (label_len != 0)
            begin
                add_label();
            end
            add_byte(8'd0);
            add_word(rec_type);
            add_word(dqmb_pkg::QCLASS_IN);
            if (edns_on)
            begin
                add_byte(8'd0);
                add_word(dqmb_pkg::OPT_TYPE);
                add_word(dqmb_pkg::OPT_SIZE);
                add_word(16'd0);
                add_word(16'd0);
                add_word(16'd0);
            end
        end
        for (int i = 0; i < msg_len; i++)
        begin
            if (carry_valid)
            begin
                w.message_word  = {carry_byte, msg_bytes[i]};
                w.bytes_in_word = dqmb_pkg::TWO_BYTES;
                w.last_word     = 1'b0;
                expected_words.push_back(w);
                carry_valid = 1'b0;
                carry_byte  = 8'd0;
            end
            else
            begin
                carry_byte  = msg_bytes[i];
                carry_valid = 1'b1;
            end
        end
        if (it.end_of_name)
        begin
            if (carry_valid)
            begin
                w.message_word  = {carry_byte, 8'd0};
                w.bytes_in_word = dqmb_pkg::ONE_BYTE;
                w.last_word     = 1'b0;
                expected_words.push_back(w);
                carry_valid = 1'b0;
                carry_byte  = 8'd0;
            end
            w = expected_words.pop_back();
            w.last_word = 1'b1;
            expected_words.push_back(w);
            in_name   = 1'b0;
            label_len = 0;
        end
    endtask

    task automatic check_word(input dqmb_pkg::word_t got);
        dqmb_pkg::word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h", got.message_word));
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.message_word !== want.message_word)
            begin
                report_mismatch($sformatf("message_word %h, expected %h",
                                          got.message_word, want.message_word));
            end
            if (got.bytes_in_word !== want.bytes_in_word)
            begin
                report_mismatch($sformatf("bytes_in_word %0d, expected %0d",
                                          got.bytes_in_word, want.bytes_in_word));
            end
            if (got.last_word !== want.last_word)
            begin
                report_mismatch($sformatf("last_word %b, expected %b",
                                          got.last_word, want.last_word));
            end
        end
    endtask

    initial
    begin
        mismatches    = 0;
        words_pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_type    = 16'd1;
            edns_on     = 1'b1;
            label_len   = 0;
            in_name     = 1'b0;
            carry_byte  = 8'd0;
            carry_valid = 1'b0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == dqmb_pkg::REG_RECORD_TYPE)
                begin
                    rec_type = cfg_data;
                end
                else if (cfg_index == dqmb_pkg::REG_EDNS_ENABLE)
                begin
                    edns_on = cfg_data[0];
                end
            end
            if (in_valid && in_ready)
            begin
                predict_words(in_item);
            end
            if (out_valid && out_ready)
            begin
                check_word(out_word);
            end
        end
        words_pending = expected_words.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int PHASE_ITEMS  = 75;
    localparam int DRAIN_CYCLES = 100;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          mismatches;
    int          words_pending;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    dqmb_stream_if #(.T(dqmb_pkg::item_t)) chars_if ();
    dqmb_stream_if #(.T(dqmb_pkg::word_t)) words_if ();

    dns_query_message_builder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .words     (words_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    query_word_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (chars_if.valid),
        .in_ready      (chars_if.ready),
        .in_item       (chars_if.data),
        .out_valid     (words_if.valid),
        .out_ready     (words_if.ready),
        .out_word      (words_if.data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        words_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_fields(input logic [15:0] qid, input logic [7:0] ch,
                               input logic bv, input logic eon);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(negedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.data  <= '{query_id: qid, name_byte: ch, byte_valid: bv, end_of_name: eon};
        do
            @(posedge clk);
        while (!chars_if.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_config(input logic [15:0] rtype, input logic edns);
        cfg_we    <= 1'b1;
        cfg_index <= dqmb_pkg::REG_RECORD_TYPE;
        cfg_data  <= rtype;
        @(negedge clk);
        cfg_index <= dqmb_pkg::REG_EDNS_ENABLE;
        cfg_data  <= {15'd0, edns};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        chars_if.valid <= 1'b0;
        @(negedge clk);
        while (words_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_name();
        int         labels;
        int         len;
        int         style;
        logic       last_label;
        logic [7:0] ch;
        labels = $urandom_range(1, 4);
        style  = $urandom_range(2);
        for (int l = 0; l < labels; l++)
        begin
            last_label = (l == labels - 1);
            len = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(8);
            if (last_label && style == 0 && len == 0)
            begin
                len = 1;
            end
            for (int i = 0; i < len; i++)
            begin
                ch = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(97, 122));
                if (ch == dqmb_pkg::DOT_CHAR)
                begin
                    ch = 8'h2D;
                end
                send_fields(16'($urandom), ch, 1'b1,
                            last_label && style == 0 && i == len - 1);
            end
            if (!last_label)
            begin
                send_fields(16'($urandom), dqmb_pkg::DOT_CHAR, 1'b1, 1'b0);
            end
            else if (style == 1)
            begin
                send_fields(16'($urandom), 8'($urandom), 1'b0, 1'b1);
            end
            else if (style == 2)
            begin
                send_fields(16'($urandom), dqmb_pkg::DOT_CHAR, 1'b1, 1'b1);
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [15:0] rtype, input logic edns);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_config(rtype, edns);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_name();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_fields(16'($urandom), 8'($urandom), 1'($urandom),
                                $urandom_range(3) == 0);
            end
        end
        send_fields(16'($urandom), 8'($urandom), 1'($urandom), 1'b1);
        wait_idle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        chars_if.valid = 1'b0;
        chars_if.data  = '0;
        words_if.ready = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = dqmb_pkg::REG_RECORD_TYPE;
        cfg_data       = 16'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_fields(16'hFFFF, 8'h61, 1'b1, 1'b0);
        send_fields(16'h0000, 8'h00, 1'b0, 1'b1);
        send_fields(16'h0000, 8'h00, 1'b1, 1'b0);
        send_fields(16'hFFFF, dqmb_pkg::DOT_CHAR, 1'b1, 1'b0);
        send_fields(16'h0000, dqmb_pkg::DOT_CHAR, 1'b1, 1'b0);
        send_fields(16'hFFFF, 8'hFF, 1'b1, 1'b1);
        send_fields(16'h1234, 8'h00, 1'b0, 1'b1);
        send_fields(16'hA5A5, 8'h62, 1'b1, 1'b0);
        send_fields(16'h5A5A, dqmb_pkg::DOT_CHAR, 1'b1, 1'b1);
        send_fields(16'h5A5A, 8'h63, 1'b1, 1'b0);
        send_fields(16'hA5A5, dqmb_pkg::DOT_CHAR, 1'b1, 1'b0);
        // The header already carries the old EDNS setting; the trailer uses the new one.
        wait_idle();
        write_config(16'd28, 1'b0);
        send_fields(16'hFFFF, 8'h64, 1'b1, 1'b0);
        send_fields(16'h0000, 8'h7F, 1'b1, 1'b1);
        wait_idle();

        run_phase(0, 0, 16'd1, 1'b1);
        run_phase(64, 0, 16'hFFFF, 1'b0);
        run_phase(0, 64, 16'd0, 1'b1);
        run_phase(24, 24, 16'($urandom), 1'($urandom));

        if (mismatches == 0 && words_pending == 0)
        begin
            $display("** dns_query_message_builder: PASSED **");
        end
        else
        begin
            $display("** dns_query_message_builder: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("** dns_query_message_builder: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dqmb_pkg.sv
hw/rtl/dqmb_stream_if.sv
hw/rtl/dqmb_ctrl.sv
hw/rtl/dqmb_datapath.sv
hw/rtl/dns_query_message_builder.sv
verif/query_word_checker.sv
verif/testbench.sv
